### rtl/dq_pkg.sv
`default_nettype none

package dq_pkg;

    // Queue geometry
    localparam int DQ_DEPTH = 8;
    localparam int DQ_AW    = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
    localparam int DQ_CW    = $clog2(DQ_DEPTH + 1);
    localparam int DQ_SW    = DQ_CW + 1;
    localparam int DQ_DW    = 32;

    // Action codes carried on the input tuser
    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_FRONT  = 3'd1,
        ACT_LIST       = 3'd2,
        ACT_PUSH_FRONT = 3'd3,
        ACT_POP_BACK   = 3'd4
    } t_action;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic    push_back;
        logic    push_front;
        logic    pop_front;
        logic    pop_back;
        logic    err_load;
        t_status err_status;
        logic    idx_clr;
        logic    idx_inc;
        logic    list_rd;
        logic    data_load;
        logic    data_last;
    } t_dq_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_last;
        logic out_free;
    } t_dq_sts;

    // Fold a sum below twice the depth back into a buffer index
    function automatic logic [DQ_AW-1:0] dq_wrap(input logic [DQ_SW-1:0] sum);
        logic [DQ_SW-1:0] red;
        red = (sum >= DQ_SW'(DQ_DEPTH)) ? (sum - DQ_SW'(DQ_DEPTH)) : sum;
        return red[DQ_AW-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/dq_ram.sv
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/dq_dpath.sv
`default_nettype none

module dq_dpath
    import dq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dq_cmd           i_cmd,
    input  wire logic [DQ_DW-1:0]  i_value,
    input  wire logic              i_m_tready,
    output t_dq_sts                o_sts,
    output logic                   o_m_tvalid,
    output logic [DQ_DW-1:0]       o_m_tdata,
    output t_status                o_m_tuser,
    output logic                   o_m_tlast
);

    logic [DQ_AW-1:0] r_head, n_head;
    logic [DQ_CW-1:0] r_count, n_count;
    logic [DQ_AW-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [DQ_DW-1:0] r_data, n_data;
    t_status          r_status, n_status;
    logic             r_last, n_last;

    logic [DQ_AW-1:0] head_inc, head_dec, pos_back, pos_last, pos_list;
    logic [DQ_AW-1:0] waddr, raddr;
    logic [DQ_SW-1:0] sum_back, sum_list;
    logic [DQ_DW-1:0] rd_data;
    logic             we, re;

    // Buffer index arithmetic
    assign head_inc = (r_head == DQ_AW'(DQ_DEPTH - 1)) ? '0 : r_head + DQ_AW'(1);
    assign head_dec = (r_head == '0) ? DQ_AW'(DQ_DEPTH - 1) : r_head - DQ_AW'(1);
    assign sum_back = DQ_SW'(r_head) + DQ_SW'(r_count);
    assign sum_list = DQ_SW'(r_head) + DQ_SW'(r_idx);
    assign pos_back = dq_wrap(sum_back);
    assign pos_last = dq_wrap(sum_back - DQ_SW'(1));
    assign pos_list = dq_wrap(sum_list);

    // Storage ports
    assign we    = i_cmd.push_back | i_cmd.push_front;
    assign waddr = i_cmd.push_back ? pos_back : head_dec;
    assign re    = i_cmd.pop_front | i_cmd.pop_back | i_cmd.list_rd;
    assign raddr = i_cmd.pop_front ? r_head : (i_cmd.pop_back ? pos_last : pos_list);

    dq_ram #(
        .WIDTH (DQ_DW),
        .DEPTH (DQ_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Status back to the controller
    assign o_sts.full     = (r_count == DQ_CW'(DQ_DEPTH));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.idx_last = ((DQ_CW'(r_idx) + DQ_CW'(1)) == r_count);
    assign o_sts.out_free = ~r_out_valid | i_m_tready;

    // Next-state for pointers, list index and output word
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_data      = r_data;
        n_status    = r_status;
        n_last      = r_last;

        if (i_cmd.push_back) begin
            n_count = r_count + DQ_CW'(1);
        end
        if (i_cmd.push_front) begin
            n_head  = head_dec;
            n_count = r_count + DQ_CW'(1);
        end
        if (i_cmd.pop_front) begin
            n_head  = head_inc;
            n_count = r_count - DQ_CW'(1);
        end
        if (i_cmd.pop_back) begin
            n_count = r_count - DQ_CW'(1);
        end
        if (i_cmd.err_load && (i_cmd.err_status == ST_UNDER)) begin
            n_head = '0;
        end

        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + DQ_AW'(1);
        end

        if (we) begin
            n_out_valid = 1'b1;
            n_data      = i_value;
            n_status    = ST_OK;
            n_last      = 1'b1;
        end else if (i_cmd.err_load) begin
            n_out_valid = 1'b1;
            n_data      = '0;
            n_status    = i_cmd.err_status;
            n_last      = 1'b1;
        end else if (i_cmd.data_load) begin
            n_out_valid = 1'b1;
            n_data      = rd_data;
            n_status    = ST_OK;
            n_last      = i_cmd.data_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_data   <= n_data;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    // Occupancy never goes past the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DQ_CW'(DQ_DEPTH))
        else $error("queue count beyond depth");

    // A result is never loaded over a word the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(we || i_cmd.err_load || i_cmd.data_load))
        else $error("output word overwritten");

    // No push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_count != DQ_CW'(DQ_DEPTH)))
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_front || i_cmd.pop_back) |=> (r_count == $past(r_count) - DQ_CW'(1)))
        else $error("pop did not drop count by one");

endmodule

`default_nettype wire

### rtl/dq_ctrl.sv
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic [2:0]  i_action,
    input  wire t_dq_sts     i_sts,
    output logic             o_s_tready,
    output t_dq_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LRD,
        S_DATA
    } t_state;

    t_state  r_state, n_state;
    logic    r_listing, n_listing;
    t_action act;
    logic    ready;

    assign act        = t_action'(i_action);
    assign ready      = (r_state == S_IDLE) && i_sts.out_free;
    assign o_s_tready = ready;

    // Decode actions and sequence reads
    always_comb begin
        n_state   = r_state;
        n_listing = r_listing;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && ready) begin
                    case (act)
                        ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                            if (i_sts.full) begin
                                o_cmd.err_load   = 1'b1;
                                o_cmd.err_status = ST_OVER;
                            end else begin
                                o_cmd.push_back  = (act == ACT_PUSH_BACK);
                                o_cmd.push_front = (act == ACT_PUSH_FRONT);
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK: begin
                            if (i_sts.empty) begin
                                o_cmd.err_load   = 1'b1;
                                o_cmd.err_status = ST_UNDER;
                            end else begin
                                o_cmd.pop_front = (act == ACT_POP_FRONT);
                                o_cmd.pop_back  = (act == ACT_POP_BACK);
                                n_listing       = 1'b0;
                                n_state         = S_DATA;
                            end
                        end
                        ACT_LIST: begin
                            if (i_sts.empty) begin
                                o_cmd.err_load   = 1'b1;
                                o_cmd.err_status = ST_EMPTY;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_listing     = 1'b1;
                                n_state       = S_LRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LRD: begin
                o_cmd.list_rd = 1'b1;
                n_state       = S_DATA;
            end
            S_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.data_load = 1'b1;
                    o_cmd.data_last = ~r_listing | i_sts.idx_last;
                    if (r_listing && !i_sts.idx_last) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_LRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_listing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_listing <= n_listing;
        end
    end

endmodule

`default_nettype wire

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words, DQ_DEPTH entries deep.
// Input stream: tuser selects the action (push back, pop front, list,
// push front, pop back), tdata carries the word to push. Output stream:
// tdata is the pushed, popped or listed word (zero on error), tuser the
// status (ok, overflow, underflow, empty), tlast marks the final word an
// input produces. Unknown action codes are taken and produce nothing.
// Pushes and errors: the result word is registered at acceptance and
// appears in the cycle after; with the sink ready, one push or error
// word per cycle. Pops: the storage RAM read port is registered, so a
// popped word is loaded in a DATA state before the next input is taken.
// Lists do one RAM read and one output load per entry, taking no input.
// The output register decouples the sides: a new input is accepted in the
// cycle its predecessor's word is taken. When the sink stalls, the result
// word holds and input tready stays low until that word leaves.
// Reset (synchronous, active low) empties the queue and drops any pending
// output word; storage contents are not cleared.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DQ_DW-1:0]  i_s_tdata,   // [31:0] value
    input  wire logic [2:0]        i_s_tuser,   // [2:0] action
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DQ_DW-1:0]       o_m_tdata,   // [31:0] data
    output logic [1:0]             o_m_tuser,   // [1:0] status
    output logic                   o_m_tlast
);

    t_dq_cmd cmd;
    t_dq_sts sts;
    t_status m_status;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    dq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (m_status),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tuser = m_status;

endmodule

`default_nettype wire
